[src/wdcl_pkg.sv]
// Package for the WAV data chunk locator.
// Word and result structs, status codes, tag constants and a tag byte helper.
// No dependencies.
package wdcl_pkg;

    localparam logic [31:0] ID_RIFF      = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE      = 32'h5741_5645;
    localparam logic [31:0] ID_DATA      = 32'h6461_7461;
    localparam logic [31:0] MIN_FILE_LEN = 32'd44;
    localparam logic [32:0] FIRST_CHUNK  = 33'd12;
    localparam logic [32:0] POS_MAX      = 33'h1_FFFF_FFFF;
    localparam logic [31:0] SEEN_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_HDR = 2'd2,
        ST_NO_DATA = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        t_status     parse_status;
        logic [31:0] pcm_offset;
        logic [31:0] pcm_length;
    } t_result;

    // byte k of a four-character tag, first character at k = 0
    function automatic logic [7:0] f_tag_byte(input logic [31:0] tag, input logic [1:0] k);
        logic [31:0] sh;
        sh = tag >> {~k, 3'b000};
        return sh[7:0];
    endfunction

endpackage

[src/wdcl_if.sv]
// Valid/ready channel interfaces for the WAV data chunk locator.
// Input word channel and result word channel. No dependencies.
interface wdcl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       final_byte;

    modport source (output valid, output file_byte, output final_byte, input ready);
    modport sink   (input valid, input file_byte, input final_byte, output ready);
endinterface

interface wdcl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  parse_status;
    logic [31:0] pcm_offset;
    logic [31:0] pcm_length;

    modport source (output valid, output parse_status, output pcm_offset,
                    output pcm_length, input ready);
    modport sink   (input valid, input parse_status, input pcm_offset,
                    input pcm_length, output ready);
endinterface

[src/wdcl_in_stage.sv]
// Input register of the WAV data chunk locator.
// Holds one accepted word until the parser takes it. Uses wdcl_pkg.
module wdcl_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  wdcl_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_take,
    output logic           o_valid,
    output wdcl_pkg::t_item o_item
);
    import wdcl_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[src/wdcl_parser.sv]
// Parsing state of the WAV data chunk locator.
// Tag checks, chunk walk and result forming for one word. Uses wdcl_pkg.
module wdcl_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  wdcl_pkg::t_item   i_item,
    output logic              o_result_valid,
    output wdcl_pkg::t_result o_result
);
    import wdcl_pkg::*;

    logic [31:0] r_bytes_seen, n_bytes_seen;
    logic [32:0] r_next, n_next;
    logic [31:0] r_id, n_id;
    logic [31:0] r_size, n_size;
    logic        r_bad, n_bad;
    logic        r_found, n_found;
    logic [31:0] r_off, n_off;
    logic [31:0] r_len, n_len;

    logic [32:0] idx33;
    logic [32:0] rel;
    logic        in_chunk;
    logic [34:0] np_sum;
    logic [34:0] np_pad;
    logic [32:0] d_bytes_seen, d_next_sum;
    t_result     res;

    assign idx33  = {1'b0, r_bytes_seen};
    assign rel    = idx33 - r_next;
    assign np_sum = {2'b00, r_next} + 35'd8 + {3'b000, n_size};
    assign np_pad = np_sum + {34'd0, np_sum[0]};
    assign d_next_sum = r_next + 33'd8;

    always_comb begin
        n_bytes_seen = r_bytes_seen;
        n_next       = r_next;
        n_id         = r_id;
        n_size       = r_size;
        n_bad        = r_bad;
        n_found      = r_found;
        n_off        = r_off;
        n_len        = r_len;
        in_chunk     = !r_found && (idx33 >= r_next);
        d_bytes_seen = 33'd0;

        if (r_bytes_seen != SEEN_MAX) begin
            if (r_bytes_seen < 32'd4 &&
                i_item.file_byte != f_tag_byte(ID_RIFF, r_bytes_seen[1:0])) begin
                n_bad = 1'b1;
            end
            if (r_bytes_seen >= 32'd8 && r_bytes_seen < 32'd12 &&
                i_item.file_byte != f_tag_byte(ID_WAVE, r_bytes_seen[1:0])) begin
                n_bad = 1'b1;
            end

            if (in_chunk && rel < 33'd8) begin
                if (!rel[2]) begin
                    n_id = {r_id[23:0], i_item.file_byte};
                end else begin
                    n_size = {i_item.file_byte, r_size[31:8]};
                    if (rel[1:0] == 2'd3) begin
                        if (r_id == ID_DATA) begin
                            n_found = 1'b1;
                            n_off   = d_next_sum[31:0];
                            n_len   = n_size;
                        end else if (np_pad > {2'b00, POS_MAX}) begin
                            n_next = POS_MAX;
                        end else begin
                            n_next = np_pad[32:0];
                        end
                    end
                end
            end

            d_bytes_seen = idx33 + 33'd1;
            n_bytes_seen = d_bytes_seen[31:0];
        end

        res.pcm_offset = 32'd0;
        res.pcm_length = 32'd0;
        if (n_bytes_seen < MIN_FILE_LEN) begin
            res.parse_status = ST_SHORT;
        end else if (n_bad) begin
            res.parse_status = ST_BAD_HDR;
        end else if (n_found) begin
            res.parse_status = ST_FOUND;
            res.pcm_offset   = n_off;
            res.pcm_length   = n_len;
        end else begin
            res.parse_status = ST_NO_DATA;
        end
    end

    assign o_result_valid = i_advance && i_item.final_byte;
    assign o_result       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.final_byte)) begin
            r_bytes_seen <= 32'd0;
            r_next       <= FIRST_CHUNK;
            r_id         <= 32'd0;
            r_size       <= 32'd0;
            r_bad        <= 1'b0;
            r_found      <= 1'b0;
            r_off        <= 32'd0;
            r_len        <= 32'd0;
        end else if (i_advance) begin
            r_bytes_seen <= n_bytes_seen;
            r_next       <= n_next;
            r_id         <= n_id;
            r_size       <= n_size;
            r_bad        <= n_bad;
            r_found      <= n_found;
            r_off        <= n_off;
            r_len        <= n_len;
        end
    end

endmodule

[src/wdcl_out_stage.sv]
// Result register of the WAV data chunk locator.
// Holds one result word until the sink takes it. Uses wdcl_pkg.
module wdcl_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wdcl_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output wdcl_pkg::t_result o_result
);
    import wdcl_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[src/wav_data_chunk_locator_top.sv]
// Channel  | dir | payload                                      | handshake
// i_in     | in  | file_byte[7:0], final_byte                   | valid/ready
// o_out    | out | parse_status[1:0], pcm_offset, pcm_length    | valid/ready
//
// One word is taken every cycle unless a final word waits on a stalled result
// register; the single combinational parse step sits between the input register
// and the result register. A word is registered, then parsed while it sits in the
// input register; a final word's result is loaded into the result register at the
// same edge as the parse state moves on.
// i_rst_n is synchronous, active low; it empties both stages and sets the
// parse state to its start values. Only a final word meeting a full, stalled
// result register holds the input; ordinary words always flow.
//
// Top level of the WAV data chunk locator.
// Uses wdcl_pkg, wdcl_if, wdcl_in_stage, wdcl_parser, wdcl_out_stage.
module wav_data_chunk_locator_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wdcl_in_if.sink         i_in,
    wdcl_out_if.source      o_out
);
    import wdcl_pkg::*;

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_take;
    logic    w_out_free;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out_res;

    assign w_in_item.file_byte  = i_in.file_byte;
    assign w_in_item.final_byte = i_in.final_byte;

    // a word may leave the input register unless it ends a file and the
    // result register cannot take its result
    assign w_take = w_item_valid && (!w_item.final_byte || w_out_free);

    wdcl_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (w_in_item),
        .o_ready (i_in.ready),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    // chunk walk and header checks; returns to start values after a final word
    wdcl_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_take),
        .i_item         (w_item),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    wdcl_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_valid),
        .i_result (w_res),
        .o_free   (w_out_free),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (w_out_res)
    );

    assign o_out.parse_status = w_out_res.parse_status;
    assign o_out.pcm_offset   = w_out_res.pcm_offset;
    assign o_out.pcm_length   = w_out_res.pcm_length;

`ifndef ASSERT_OFF
    // input held back only by a pending final word behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (w_item_valid && w_item.final_byte && o_out.valid && !o_out.ready))
        else $error("input stalled without a blocked final word");

    // offset and length are zero unless a data chunk was found
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && w_out_res.parse_status != ST_FOUND)
            |-> (o_out.pcm_offset == 32'd0 && o_out.pcm_length == 32'd0))
        else $error("non-zero fields on a result without data");

    // first chunk header ends at byte 20 at the earliest
    a_found_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && w_out_res.parse_status == ST_FOUND)
            |-> (o_out.pcm_offset >= 32'd20))
        else $error("data offset before the first chunk body");
`endif

endmodule

[dv/wav_data_chunk_locator_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for wav_data_chunk_locator_top: WAV byte streams in,
// one result per file. Depends on wdcl_pkg and the wdcl_in_if / wdcl_out_if interfaces.
import wdcl_pkg::*;

// Tracks the parse of the file in flight and holds the result words still owed.
class data_chunk_scoreboard;
    logic [31:0] seen_cnt;
    logic [32:0] chunk_pos;
    logic [31:0] id_shift;
    logic [31:0] size_shift;
    logic        tag_bad;
    logic        got_data;
    logic [31:0] found_off;
    logic [31:0] found_len;
    t_result     awaited[$];
    int          err_cnt;

    function new();
        err_cnt = 0;
        clear_file();
    endfunction

    function void clear_file();
        seen_cnt   = '0;
        chunk_pos  = FIRST_CHUNK;
        id_shift   = '0;
        size_shift = '0;
        tag_bad    = 1'b0;
        got_data   = 1'b0;
        found_off  = '0;
        found_len  = '0;
    endfunction

    task report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    // one byte at stream index idx
    function void walk_byte(input logic [31:0] idx, input logic [7:0] b);
        logic [32:0] rel;
        logic [33:0] nxt;
        if (idx < 4) begin
            if (b != ID_RIFF[8*(3-idx[1:0]) +: 8]) tag_bad = 1'b1;
        end else if (idx >= 8 && idx < 12) begin
            if (b != ID_WAVE[8*(3-idx[1:0]) +: 8]) tag_bad = 1'b1;
        end
        if (got_data || {1'b0, idx} < chunk_pos) return;
        rel = {1'b0, idx} - chunk_pos;
        if (rel < 4) begin
            id_shift = {id_shift[23:0], b};
        end else if (rel < 8) begin
            size_shift = {b, size_shift[31:8]};   // little-endian size
            if (rel == 7) begin
                if (id_shift == ID_DATA) begin
                    got_data  = 1'b1;
                    found_off = chunk_pos[31:0] + 32'd8;
                    found_len = size_shift;
                end else begin
                    nxt = {1'b0, chunk_pos} + 34'd8 + {2'b00, size_shift};
                    if (nxt[0]) nxt = nxt + 34'd1;
                    if (nxt > {1'b0, POS_MAX}) nxt = {1'b0, POS_MAX};
                    chunk_pos = nxt[32:0];
                end
            end
        end
    endfunction

    task note_word(input logic [7:0] b, input logic fin);
        t_result r;
        if (seen_cnt != SEEN_MAX) begin
            walk_byte(seen_cnt, b);
            seen_cnt++;
        end
        if (!fin) return;
        r = '0;
        if (seen_cnt < MIN_FILE_LEN) begin
            r.parse_status = ST_SHORT;
        end else if (tag_bad) begin
            r.parse_status = ST_BAD_HDR;
        end else if (got_data) begin
            r.parse_status = ST_FOUND;
            r.pcm_offset   = found_off;
            r.pcm_length   = found_len;
        end else begin
            r.parse_status = ST_NO_DATA;
        end
        awaited.push_back(r);
        clear_file();
    endtask

    task check_result(input t_result got);
        t_result want;
        if (awaited.size() == 0) begin
            report($sformatf("result word with none awaited, parse_status %0d",
                             got.parse_status));
            return;
        end
        want = awaited.pop_front();
        if (got.parse_status != want.parse_status)
            report($sformatf("parse_status %0d, want %0d",
                             got.parse_status, want.parse_status));
        if (got.pcm_offset != want.pcm_offset)
            report($sformatf("pcm_offset %0d, want %0d",
                             got.pcm_offset, want.pcm_offset));
        if (got.pcm_length != want.pcm_length)
            report($sformatf("pcm_length %0d, want %0d",
                             got.pcm_length, want.pcm_length));
    endtask
endclass

module wav_data_chunk_locator_top_test;
    localparam int IDLE_PCT         = 11;
    localparam int STALL_LIMIT      = 1000;   // cycles with no word moving on either side
    localparam int RANDOM_WORDS     = 1070;
    localparam int DRAIN_CYCLES     = 8;      // result lags the final word through the result register

    // chunk ids that are not "data"
    localparam logic [31:0] ID_FMT  = "fmt ";
    localparam logic [31:0] ID_LIST = "LIST";
    localparam logic [31:0] ID_NEAR = "datb";
    localparam logic [31:0] ID_CAPS = "Data";

    logic                 clk;
    logic                 rst_n;
    int                   idle_pct;
    int                   stall_cnt;
    int                   words_sent;
    logic [7:0]           file_words[$];
    data_chunk_scoreboard sb;

    wdcl_in_if  in_if();
    wdcl_out_if out_if();

    wav_data_chunk_locator_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side back-pressure, same idle rate as the sender
    always @(negedge clk) begin
        out_if.ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    // Monitor: both channels sampled at the rising edge, plus the stall watchdog.
    always @(posedge clk) begin
        t_result got;
        if (rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_word(in_if.file_byte, in_if.final_byte);
            if (out_if.valid && out_if.ready) begin
                got.parse_status = t_status'(out_if.parse_status);
                got.pcm_offset   = out_if.pcm_offset;
                got.pcm_length   = out_if.pcm_length;
                sb.check_result(got);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // File building: bytes collect in file_words, send_file streams them out.
    function automatic void add_tag(input logic [31:0] tag);
        for (int k = 3; k >= 0; k--) file_words.push_back(tag[8*k +: 8]);
    endfunction

    function automatic void add_le32(input logic [31:0] v);
        for (int k = 0; k < 4; k++) file_words.push_back(v[8*k +: 8]);
    endfunction

    function automatic void add_fill(input int n);
        repeat (n) file_words.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void add_wav_head(input logic [31:0] riff_len);
        add_tag(ID_RIFF);
        add_le32(riff_len);
        add_tag(ID_WAVE);
    endfunction

    // Called at a falling edge, returns at the falling edge after acceptance.
    // valid stays high between words unless an idle cycle is drawn.
    task automatic send_word(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.file_byte  <= b;
        in_if.final_byte <= fin;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_words.size(); i++)
            send_word(file_words[i], i == file_words.size() - 1);
        file_words.delete();
    endtask

    // Mostly well-formed files with random chunk content; some noise, broken
    // tags, missing pad bytes and files cut off at a random point.
    task automatic build_random_file();
        int          kind;
        int          n_chunks;
        int          sz;
        int          cut;
        int          pos;
        logic [31:0] id;
        logic [31:0] len;
        kind = $urandom_range(99);
        if (kind < 10) begin
            add_fill($urandom_range(1, 70));
            return;
        end
        add_wav_head($urandom());
        n_chunks = $urandom_range(0, 3);
        for (int c = 0; c < n_chunks; c++) begin
            case ($urandom_range(4))
                0:       id = ID_FMT;
                1:       id = ID_LIST;
                2:       id = ID_NEAR;
                3:       id = ID_CAPS;
                default: id = $urandom();
            endcase
            add_tag(id);
            if ($urandom_range(99) < 5) begin
                // oversized body, nothing after it is a chunk
                add_le32($urandom());
                add_fill($urandom_range(0, 20));
            end else begin
                sz = $urandom_range(0, 24);
                add_le32(sz);
                add_fill(sz);
                if (sz % 2 == 1 && $urandom_range(99) < 85) add_fill(1);
            end
        end
        if ($urandom_range(99) < 80) begin
            kind = $urandom_range(99);
            if (kind < 70)      len = $urandom_range(0, 40);
            else if (kind < 85) len = $urandom();
            else                len = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
            add_tag(ID_DATA);
            add_le32(len);
            add_fill($urandom_range(0, 40));
        end
        if ($urandom_range(99) < 20) begin
            pos = $urandom_range(0, 11);
            file_words[pos] = file_words[pos] ^ 8'(1 << $urandom_range(7));
        end
        if ($urandom_range(99) < 15) begin
            cut = $urandom_range(1, file_words.size());
            while (file_words.size() > cut) void'(file_words.pop_back());
        end
    endtask

    initial begin
        int directed_words;
        int files_done;
        in_if.valid      = 1'b0;
        in_if.file_byte  = 8'h00;
        in_if.final_byte = 1'b0;
        rst_n            = 1'b0;
        idle_pct         = IDLE_PCT;
        stall_cnt        = 0;
        words_sent       = 0;
        sb               = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed files ---
        // lone final word: too short outranks the broken tag
        file_words.push_back(8'hFF);
        send_file();
        // smallest file with a data chunk, bytes 4-7 all zero
        add_wav_head(32'h0);
        add_tag(ID_DATA);
        add_le32(32'd24);
        add_fill(24);
        send_file();
        // one word short of the minimum length
        add_wav_head(32'hFFFF_FFFF);
        add_tag(ID_DATA);
        add_le32(32'd0);
        add_fill(23);
        send_file();
        // broken RIFF tag
        add_tag("RIFX");
        add_le32(32'd36);
        add_tag(ID_WAVE);
        add_tag(ID_DATA);
        add_le32(32'd0);
        add_fill(24);
        send_file();
        // broken WAVE tag
        add_tag(ID_RIFF);
        add_le32(32'd36);
        add_tag("WAVF");
        add_tag(ID_DATA);
        add_le32(32'd0);
        add_fill(24);
        send_file();
        // final word completes the data header, largest declared size
        add_wav_head($urandom());
        add_tag(ID_FMT);
        add_le32(32'd16);
        add_fill(16);
        add_tag(ID_DATA);
        add_le32(32'hFFFF_FFFF);
        send_file();
        // data header cut off by the end of file
        add_wav_head($urandom());
        add_tag(ID_FMT);
        add_le32(32'd18);
        add_fill(18);
        add_tag(ID_DATA);
        add_le32(32'd0);
        void'(file_words.pop_back());
        void'(file_words.pop_back());
        send_file();
        // odd chunk plus pad, then two data chunks: only the first counts
        add_wav_head($urandom());
        add_tag(ID_LIST);
        add_le32(32'd1);
        add_fill(2);
        add_tag(ID_DATA);
        add_le32(32'd3);
        add_fill(4);
        add_tag(ID_DATA);
        add_le32(32'd7);
        add_fill(20);
        send_file();
        // oversized chunk hides the data chunk behind it
        add_wav_head($urandom());
        add_tag(ID_NEAR);
        add_le32(32'hFFFF_FFFF);
        add_tag(ID_DATA);
        add_le32(32'd8);
        add_fill(30);
        send_file();
        // near-miss ids only, no data chunk
        add_wav_head($urandom());
        add_tag(ID_CAPS);
        add_le32(32'd4);
        add_fill(4);
        add_tag(ID_NEAR);
        add_le32(32'd10);
        add_fill(10);
        add_tag(ID_FMT);
        add_le32(32'd0);
        send_file();

        // --- random files ---
        directed_words = words_sent;
        files_done     = 0;
        while (words_sent < directed_words + RANDOM_WORDS) begin
            // a run of files with both sides streaming flat out
            idle_pct = (files_done >= 4 && files_done < 10) ? 0 : IDLE_PCT;
            build_random_file();
            send_file();
            files_done++;
        end
        in_if.valid <= 1'b0;
        idle_pct    = IDLE_PCT;

        // drain, then a short quiet spell to catch any stray result word
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
